// ===== src/mck_pkg.sv =====
// Shared types, constants and the Morse tree lookup for the Morse code keyer.
package mck_pkg;

    localparam int CHAR_W       = 8;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int LEFT_W       = 3;
    localparam int TREE_ENTRIES = 128;
    localparam int TREE_IDX_W   = $clog2(TREE_ENTRIES);
    localparam int TDATA_IN_W   = 8;
    localparam int TDATA_OUT_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] LOWER_LIMIT = 8'd96;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

    localparam logic KIND_CHAR = 1'b1;

    localparam logic [CFG_W-1:0] DOT_TICKS_RST  = 16'd60;
    localparam logic [CFG_W-1:0] DASH_TICKS_RST = 16'd180;
    localparam logic [CFG_W-1:0] WORD_TICKS_RST = 16'd420;

    typedef enum logic [1:0] {
        SYM_DOT   = 2'd0,
        SYM_DASH  = 2'd1,
        SYM_SENT  = 2'd2,
        SYM_SPACE = 2'd3
    } sym_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOT  = 2'd0,
        CFG_DASH = 2'd1,
        CFG_WORD = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] dot_ticks;
        logic [CFG_W-1:0] dash_ticks;
        logic [CFG_W-1:0] word_space_ticks;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] char_code;
    } item_t;

    typedef struct packed {
        logic accepted;
        logic busy_res;
        logic tone_on;
    } result_t;

    // Heap index of an upper-case character in the dichotomic tree; 0 when absent
    function automatic logic [TREE_IDX_W-1:0] tree_index(input logic [CHAR_W-1:0] c);
        logic [TREE_IDX_W-1:0] idx;
        case (c)
            "E":   idx = 7'd1;
            "T":   idx = 7'd2;
            "I":   idx = 7'd3;
            "A":   idx = 7'd4;
            "N":   idx = 7'd5;
            "M":   idx = 7'd6;
            "S":   idx = 7'd7;
            "U":   idx = 7'd8;
            "R":   idx = 7'd9;
            "W":   idx = 7'd10;
            "D":   idx = 7'd11;
            "K":   idx = 7'd12;
            "G":   idx = 7'd13;
            "O":   idx = 7'd14;
            "H":   idx = 7'd15;
            "V":   idx = 7'd16;
            "F":   idx = 7'd17;
            "L":   idx = 7'd19;
            "P":   idx = 7'd21;
            "J":   idx = 7'd22;
            "B":   idx = 7'd23;
            "X":   idx = 7'd24;
            "C":   idx = 7'd25;
            "Y":   idx = 7'd26;
            "Z":   idx = 7'd27;
            "Q":   idx = 7'd28;
            8'h21: idx = 7'd29;  // !
            "5":   idx = 7'd31;
            "4":   idx = 7'd32;
            "3":   idx = 7'd34;
            "2":   idx = 7'd38;
            8'h26: idx = 7'd39;  // &
            8'h2B: idx = 7'd41;  // +
            "1":   idx = 7'd46;
            "6":   idx = 7'd47;
            8'h3D: idx = 7'd48;  // =
            8'h2F: idx = 7'd49;  // /
            8'h28: idx = 7'd53;  // (
            "7":   idx = 7'd55;
            "8":   idx = 7'd59;
            "9":   idx = 7'd61;
            "0":   idx = 7'd62;
            8'h3F: idx = 7'd75;  // ?
            8'h5F: idx = 7'd76;  // _
            8'h22: idx = 7'd81;  // double quote
            8'h2E: idx = 7'd84;  // .
            8'h40: idx = 7'd89;  // @
            8'h27: idx = 7'd93;  // apostrophe
            8'h2D: idx = 7'd96;  // -
            8'h3B: idx = 7'd105; // ;
            8'h29: idx = 7'd108; // )
            8'h2C: idx = 7'd114; // ,
            8'h3A: idx = 7'd119; // :
            default: idx = '0;
        endcase
        return idx;
    endfunction

endpackage

// ===== src/mck_cfg_regs.sv =====
// Timing configuration registers of the Morse code keyer.
module mck_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mck_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mck_pkg::CFG_W-1:0]      cfg_data,
    output mck_pkg::cfg_t                  cfg
);
    import mck_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dot_ticks        <= DOT_TICKS_RST;
            cfg_reg.dash_ticks       <= DASH_TICKS_RST;
            cfg_reg.word_space_ticks <= WORD_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DOT:  cfg_reg.dot_ticks        <= cfg_data;
                CFG_DASH: cfg_reg.dash_ticks       <= cfg_data;
                CFG_WORD: cfg_reg.word_space_ticks <= cfg_data;
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

endmodule

// ===== src/mck_in_stage.sv =====
// Input register stage of the Morse code keyer.
module mck_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mck_pkg::item_t s_item,
    input  logic           take,
    output logic           in_valid,
    output mck_pkg::item_t in_item
);
    import mck_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t item_reg;

    assign s_ready  = !in_valid_reg || take;
    assign in_valid = in_valid_reg;
    assign in_item  = item_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== src/mck_core.sv =====
// Keyer state, symbol store, per-item update and result register.
module mck_core #(
    parameter int MAX_SYMBOLS = 6,
    parameter int TIMER_BITS  = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mck_pkg::cfg_t    cfg,
    input  logic             in_valid,
    input  mck_pkg::item_t   in_item,
    output logic             take,
    output logic             out_valid,
    input  logic             out_ready,
    output mck_pkg::result_t out_result
);
    import mck_pkg::*;

    localparam int SIDX_W = $clog2(MAX_SYMBOLS);
    localparam int CMP_W  = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;
    localparam int PATH_W = TREE_IDX_W + 1;
    localparam logic [TIMER_BITS-1:0] ELAPSED_MAX = '1;

    logic                  sending_reg, sending_next;
    logic [LEFT_W-1:0]     left_reg, left_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  tone_reg, tone_next;
    sym_t                  store_reg [MAX_SYMBOLS];
    sym_t                  store_next [MAX_SYMBOLS];
    logic                  out_valid_reg, out_valid_next;
    result_t               result_reg, result_next;

    logic [CHAR_W-1:0]     upper_char;
    logic [TREE_IDX_W-1:0] tree_pos;
    logic [PATH_W-1:0]     path;
    logic [LEFT_W-1:0]     depth;
    logic [LEFT_W-1:0]     sym_count;
    logic                  char_ok;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [LEFT_W-1:0]     left_m1;
    logic [LEFT_W-1:0]     left_clamp;
    logic [SIDX_W-1:0]     cur_idx;
    sym_t                  cur_sym;
    logic                  last_sym;
    logic [CMP_W-1:0]      inc_x, dot_x, dash_x, word_x;
    logic                  dot_done, dash_done, word_done;

    assign take       = in_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // Character decode: fold to upper case, find the tree node, path = node + 1
    assign char_ok    = (in_item.char_code != CHAR_NUL) && (in_item.char_code != CHAR_STAR)
                        && (left_reg == '0);
    assign upper_char = (in_item.char_code > LOWER_LIMIT) ? in_item.char_code - CASE_OFFSET
                                                          : in_item.char_code;
    assign tree_pos   = tree_index(upper_char);
    assign path       = {1'b0, tree_pos} + PATH_W'(1);

    // Depth is the position of the leading one; the bits below it are the
    // symbols, leaf in bit 0, with 0 for a dot and 1 for a dash.
    always_comb begin
        depth = '0;
        for (int i = 1; i < PATH_W; i++) begin
            if (path[i]) begin
                depth = LEFT_W'(i);
            end
        end
    end

    assign sym_count = (depth > LEFT_W'(MAX_SYMBOLS)) ? LEFT_W'(MAX_SYMBOLS) : depth;

    // Current symbol is read from the top of the filled part of the store
    assign left_m1    = left_reg - LEFT_W'(1);
    assign left_clamp = (left_m1 >= LEFT_W'(MAX_SYMBOLS)) ? LEFT_W'(MAX_SYMBOLS - 1) : left_m1;
    assign cur_idx    = left_clamp[SIDX_W-1:0];
    assign cur_sym    = store_reg[cur_idx];
    assign last_sym   = left_reg <= LEFT_W'(1);

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + TIMER_BITS'(1);
    assign inc_x     = CMP_W'(elapsed_inc);
    assign dot_x     = CMP_W'(cfg.dot_ticks);
    assign dash_x    = CMP_W'(cfg.dash_ticks);
    assign word_x    = CMP_W'(cfg.word_space_ticks);
    assign dot_done  = inc_x >= dot_x;
    assign dash_done = inc_x >= dash_x;
    // elapsed > word - dash, kept unsigned by moving dash across
    assign word_done = (inc_x + dash_x) > word_x;

    always_comb begin
        sending_next = sending_reg;
        left_next    = left_reg;
        elapsed_next = elapsed_reg;
        tone_next    = tone_reg;
        store_next   = store_reg;
        result_next  = '0;

        if (in_item.kind == KIND_CHAR) begin
            if (char_ok) begin
                result_next.accepted = 1'b1;
                if (tree_pos != '0) begin
                    for (int k = 0; k < MAX_SYMBOLS; k++) begin
                        if (k < int'(sym_count)) begin
                            store_next[k] = path[k] ? SYM_DASH : SYM_DOT;
                        end
                    end
                    tone_next = 1'b1;
                    left_next = sym_count;
                end else begin
                    store_next[0] = SYM_SPACE;
                    left_next     = LEFT_W'(1);
                end
                elapsed_next = '0;
                sending_next = 1'b1;
            end
        end else begin
            elapsed_next = elapsed_inc;
            if (left_reg == '0) begin
                sending_next = 1'b0;
            end else begin
                case (cur_sym)
                    SYM_DOT, SYM_DASH: begin
                        if ((cur_sym == SYM_DOT) ? dot_done : dash_done) begin
                            tone_next           = 1'b0;
                            store_next[cur_idx] = SYM_SENT;
                            elapsed_next        = '0;
                        end
                    end
                    SYM_SENT: begin
                        // gap after a symbol; the letter gap after the last one
                        if (!last_sym) begin
                            if (dot_done) begin
                                tone_next    = 1'b1;
                                left_next    = left_m1;
                                elapsed_next = '0;
                            end
                        end else if (dash_done) begin
                            left_next    = left_m1;
                            elapsed_next = '0;
                        end
                    end
                    default: begin
                        if (word_done) begin
                            left_next = left_m1;
                        end
                    end
                endcase
            end
        end

        result_next.tone_on  = tone_next;
        result_next.busy_res = sending_next;
    end

    always_comb begin
        if (take) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg   <= 1'b0;
            left_reg      <= '0;
            elapsed_reg   <= '0;
            tone_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                sending_reg <= sending_next;
                left_reg    <= left_next;
                elapsed_reg <= elapsed_next;
                tone_reg    <= tone_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            store_reg  <= store_next;
            result_reg <= result_next;
        end
    end

endmodule

// ===== src/morse_code_keyer.sv =====
// Top level of the Morse code keyer: stream ports, config port and stage wiring.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: char_code; s_tuser: kind
//  m_      | out       | m_tvalid/m_tready  | m_tdata: tone_on, busy_res, accepted
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle sustained while m_tready stays high. The input register loads
// at the input transaction, and the keyer update then loads the result register when the
// core takes the item. cfg_ready is always high.
// aresetn is synchronous: it clears the keyer state and both valid flags and
// restores the default dot, dash and word-space times.
// A stall on m_tready holds the result and the input register; s_tready drops when both are full.
module morse_code_keyer #(
    parameter int MAX_SYMBOLS = 6,
    parameter int TIMER_BITS  = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mck_pkg::TDATA_IN_W-1:0]   s_tdata,  // [7:0] char_code
    input  logic                             s_tuser,  // [0] kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mck_pkg::TDATA_OUT_W-1:0]  m_tdata,  // [0] tone_on, [1] busy_res,
                                                       // [2] accepted, [7:3] zero
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mck_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mck_pkg::CFG_W-1:0]        cfg_data
);
    import mck_pkg::*;

    localparam int RES_W = $bits(result_t);

    cfg_t    cfg;
    item_t   s_item;
    item_t   in_item;
    logic    in_valid;
    logic    take;
    result_t result;

    assign s_item.kind      = s_tuser;
    assign s_item.char_code = s_tdata[CHAR_W-1:0];

    mck_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mck_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_item   (s_item),
        .take     (take),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    mck_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {{(TDATA_OUT_W - RES_W){1'b0}}, result};

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the Morse code keyer: scoreboard with keying predictor plus drivers.
module testbench;
    import mck_pkg::*;

    localparam int SYM_SLOTS   = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic KIND_TICK = ~KIND_CHAR;

    // Heap-ordered dichotomic tree; position 0 is the root, '*' marks an empty node
    localparam string MORSE_TREE = {
        " ETIANMSURWDKGOHVF*L*PJBXCYZQ!*54*3***2&*+****16=/***(*7***8*90*",
        "***********?_****\"**.****@***'**-********;!*)*****,****:*******"
    };

    class keyer_scoreboard;
        logic [CFG_W-1:0] dot_len;
        logic [CFG_W-1:0] dash_len;
        logic [CFG_W-1:0] word_len;
        bit               sending;
        bit               tone;
        sym_t             slots[SYM_SLOTS];
        int unsigned      left;
        bit [CFG_W-1:0]   elapsed;
        result_t          awaited[$];
        bit               last_taken;
        int               errors;
        int               checked;
        int               taken;
        int               spaces;
        int               turned_away;
        int               ticks;

        function new();
            dot_len  = DOT_TICKS_RST;
            dash_len = DASH_TICKS_RST;
            word_len = WORD_TICKS_RST;
            sending  = 0;
            tone     = 0;
            left     = 0;
            elapsed  = '0;
            foreach (slots[i]) slots[i] = SYM_DOT;
            errors = 0; checked = 0; taken = 0; spaces = 0; turned_away = 0; ticks = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_DOT:  dot_len  = val;
                CFG_DASH: dash_len = val;
                CFG_WORD: word_len = val;
                default: ;
            endcase
        endfunction

        function int heap_position(logic [CHAR_W-1:0] c);
            int i;
            for (i = 1; i < MORSE_TREE.len(); i++)
                if (MORSE_TREE[i] == c) return i;
            return 0;
        endfunction

        function bit load_char(logic [CHAR_W-1:0] c);
            logic [CHAR_W-1:0] up;
            int node;
            int n;
            if (c == CHAR_NUL || c == CHAR_STAR || left != 0) return 1'b0;
            up = (c > LOWER_LIMIT) ? c - CASE_OFFSET : c;
            node = heap_position(up);
            n = 0;
            if (node > 0) begin
                // walk leaf to root; slots are played from the top index down
                while (node > 0 && n < SYM_SLOTS) begin
                    slots[n] = (node % 2 == 1) ? SYM_DOT : SYM_DASH;
                    n++;
                    node = (node - 1) / 2;
                end
                tone = 1'b1;
            end else begin
                slots[0] = SYM_SPACE;
                n = 1;
                spaces++;
            end
            left    = n;
            elapsed = '0;
            sending = 1'b1;
            return 1'b1;
        endfunction

        function void advance_tick();
            int unsigned idx;
            sym_t        cur;
            bit          last;
            if (elapsed != '1) elapsed++;
            if (left == 0) begin
                sending = 1'b0;
                return;
            end
            idx  = left - 1;
            cur  = slots[idx];
            last = (left <= 1);
            case (cur)
                SYM_DOT, SYM_DASH: begin
                    if (elapsed >= ((cur == SYM_DOT) ? dot_len : dash_len)) begin
                        tone       = 1'b0;
                        slots[idx] = SYM_SENT;
                        elapsed    = '0;
                    end
                end
                SYM_SENT: begin
                    if (!last) begin
                        if (elapsed >= dot_len) begin
                            tone    = 1'b1;
                            left--;
                            elapsed = '0;
                        end
                    end else if (elapsed >= dash_len) begin
                        left--;
                        elapsed = '0;
                    end
                end
                default: begin
                    // word pause: signed compare, so a short word time ends it at once
                    if (int'(elapsed) > int'(word_len) - int'(dash_len)) left--;
                end
            endcase
        endfunction

        function void note_item(logic kind, logic [CHAR_W-1:0] code);
            result_t want;
            last_taken = 1'b0;
            if (kind == KIND_CHAR) begin
                last_taken = load_char(code);
                if (last_taken) taken++;
                else turned_away++;
            end else begin
                advance_tick();
                ticks++;
            end
            want.tone_on  = tone;
            want.busy_res = sending;
            want.accepted = last_taken;
            awaited.push_back(want);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 20)
                $display("MISMATCH %s: got %0d expected %0d (result %0d)",
                         field, got, want, checked);
        endtask

        task check_result(logic [TDATA_OUT_W-1:0] word);
            result_t got;
            result_t want;
            got = word[2:0];
            if (awaited.size() == 0) begin
                report("unexpected result", 32'(word), 32'(0));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.tone_on !== want.tone_on)
                report("tone_on", 32'(got.tone_on), 32'(want.tone_on));
            if (got.busy_res !== want.busy_res)
                report("busy_res", 32'(got.busy_res), 32'(want.busy_res));
            if (got.accepted !== want.accepted)
                report("accepted", 32'(got.accepted), 32'(want.accepted));
            if (word[TDATA_OUT_W-1:3] !== '0)
                report("tdata padding", 32'(word[TDATA_OUT_W-1:3]), 32'(0));
        endtask
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [TDATA_IN_W-1:0]       s_tdata;
    logic                        s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [TDATA_OUT_W-1:0]      m_tdata;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;

    keyer_scoreboard sb;
    bit              idle_on;
    int              hold_req;
    int              cycles;

    morse_code_keyer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: per-transaction random stall plus an occasional long hold-off
    initial begin
        int wait_left;
        int hold_left;
        wait_left = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                wait_left = idle_on ? $urandom_range(0, 6) : 0;
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic kind, logic [CHAR_W-1:0] code);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(kind, code);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, CHAR_W'($urandom_range(0, 255)));
    endtask

    // Sender pauses until every expected result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_timing(logic [CFG_W-1:0] dot, logic [CFG_W-1:0] dash,
                              logic [CFG_W-1:0] word);
        cfg_idx_t          idx[3];
        logic [CFG_W-1:0]  val[3];
        int                i;
        idx[0] = CFG_DOT;  val[0] = dot;
        idx[1] = CFG_DASH; val[1] = dash;
        idx[2] = CFG_WORD; val[2] = word;
        drain();
        for (i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        int                r;
        int                pos;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            pos = $urandom_range(1, MORSE_TREE.len() - 1);
            while (MORSE_TREE[pos] == CHAR_STAR) pos = $urandom_range(1, MORSE_TREE.len() - 1);
            c = MORSE_TREE[pos];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + CASE_OFFSET;
        end else if (r < 82) begin
            c = CHAR_W'($urandom_range(0, 255));
        end else if (r < 90) begin
            c = " ";
        end else if (r < 95) begin
            c = CHAR_STAR;
        end else begin
            c = CHAR_NUL;
        end
        return c;
    endfunction

    // Mostly whole characters followed by enough ticks to finish them;
    // a few characters land while symbols remain and get turned away
    task automatic traffic(int count);
        int done;
        bit want_char;
        done = 0;
        while (done < count) begin
            if (sb.left == 0) want_char = ($urandom_range(0, 99) < 60);
            else want_char = ($urandom_range(0, 99) < 8);
            if (want_char) begin
                send_item(KIND_CHAR, pick_char());
                if (sb.last_taken) done++;
            end else begin
                send_tick();
                done++;
            end
        end
    endtask

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_TICK;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DOT;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        sb       = new();
        idle_on  = 1'b1;
        hold_req = 0;
        cycles   = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // power-up timing: ignored codes, a dot, then a refused character
        send_tick();
        send_item(KIND_CHAR, CHAR_NUL);
        send_item(KIND_CHAR, CHAR_STAR);
        send_item(KIND_CHAR, "E");
        send_tick();
        send_item(KIND_CHAR, "T");

        set_timing(16'd1, 16'd1, 16'd1);
        repeat (3) send_tick();                // finish the dot, then busy drops
        send_item(KIND_CHAR, 8'hFF);           // folds to a code with no tree node
        repeat (2) send_tick();
        send_item(KIND_CHAR, "a");
        repeat (4) send_tick();
        send_item(KIND_CHAR, ":");             // six symbols, deepest node
        send_item(KIND_CHAR, " ");             // refused, symbols remain

        set_timing(16'd1, 16'd3, 16'd1);       // word time shorter than dash
        repeat (20) send_tick();
        send_item(KIND_CHAR, " ");
        send_tick();

        set_timing(16'd2, 16'd5, 16'd12);
        traffic(180);

        idle_on = 1'b0;
        set_timing(16'd3, 16'd2, 16'd1);
        traffic(150);
        idle_on = 1'b1;

        set_timing(16'd1, 16'd4, 16'd4);
        traffic(80);
        hold_req = 60;
        idle_on  = 1'b0;
        traffic(40);
        idle_on = 1'b1;
        drain();
        traffic(100);

        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(KIND_CHAR, "T");
        repeat (5) send_tick();
        send_item(KIND_CHAR, "E");

        set_timing(16'd4, 16'd9, 16'd30);
        traffic(200);

        set_timing(16'd2, 16'd3, 16'd6);
        traffic(160);
        drain();
        traffic(160);

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered %0d ticks and %0d characters taken (%0d as word spaces),",
                 sb.ticks, sb.taken, sb.spaces);
        $display("%0d characters ignored or refused, %0d results compared, %0d mismatches",
                 sb.turned_away, sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== morse_code_keyer.f =====
src/mck_pkg.sv
src/mck_cfg_regs.sv
src/mck_in_stage.sv
src/mck_core.sv
src/morse_code_keyer.sv
bench/testbench.sv
